### src/assignment_problem_solver_assert.svh
// assertion macros for the assignment problem solver
// included by the top level; no other dependencies
`ifndef ASSIGNMENT_PROBLEM_SOLVER_ASSERT_SVH
`define ASSIGNMENT_PROBLEM_SOLVER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define APS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// next-cycle implication
`define APS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define APS_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define APS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### src/aps_pkg.sv
// shared types and constants of the assignment problem solver
// no dependencies
package aps_pkg;

   // width of potentials, slack and sums
   localparam int VALUE_WIDTH = 48;
   localparam int ENTRY_PORT_WIDTH = 32;
   localparam int SIZE_REG_WIDTH = 5;
   localparam int INDEX_OUT_WIDTH = 4;
   localparam int CSR_INDEX_WIDTH = 1;

   // configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MATRIX_SIZE = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAXIMIZE_MODE = 1'b1;

   localparam logic [SIZE_REG_WIDTH-1:0] MATRIX_SIZE_RESET = 5'd16;

   // initial slack value
   localparam logic signed [VALUE_WIDTH-1:0] SLACK_TOP = 48'sh7FFF_FFFF_FFFF;

   // solve launch from the load control
   typedef struct packed {
      logic go;
      logic maximize;
   } aps_start_type;

endpackage

### src/aps_mem.sv
// cost store: one write port for loading, one registered read port
// depends on nothing but its parameters
module aps_mem #(
   parameter int ADDR_WIDTH = 8,
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  write_enable,
   input  logic [ADDR_WIDTH-1:0] write_addr,
   input  logic [DATA_WIDTH-1:0] write_data,
   input  logic [ADDR_WIDTH-1:0] read_addr,
   output logic [DATA_WIDTH-1:0] read_data
);

   logic [DATA_WIDTH-1:0] mem_ff [2**ADDR_WIDTH];
   logic [DATA_WIDTH-1:0] read_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

### src/aps_alu.sv
// shared add/subtract unit used by the arithmetic steps of the solver
// depends on aps_pkg
module aps_alu (
   input  logic signed [aps_pkg::VALUE_WIDTH-1:0] op_a,
   input  logic signed [aps_pkg::VALUE_WIDTH-1:0] op_b,
   input  logic                                   subtract,
   output logic signed [aps_pkg::VALUE_WIDTH-1:0] result
);

   // one adder, operand b inverted for subtract
   always_comb begin
      if (subtract) begin
         result = op_a - op_b;
      end else begin
         result = op_a + op_b;
      end
   end

endmodule

### src/aps_solver.sv
// hungarian method sequencer with potential, slack and path tables
// depends on aps_pkg and aps_alu; reads the cost store through a registered port
module aps_solver #(
   parameter int MAX_SIZE = 16,
   parameter int ENTRY_WIDTH = 32
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  aps_pkg::aps_start_type                      start_ctl,
   input  logic [$clog2(MAX_SIZE+1)-1:0]               size,
   output logic [2*$clog2(MAX_SIZE)-1:0]               read_addr,
   input  logic [ENTRY_WIDTH-1:0]                      read_data,
   output logic                                        active,
   output logic                                        rsp_strobe,
   output logic [aps_pkg::INDEX_OUT_WIDTH-1:0]         rsp_column_index,
   output logic [aps_pkg::INDEX_OUT_WIDTH-1:0]         rsp_assigned_row,
   output logic signed [aps_pkg::ENTRY_PORT_WIDTH-1:0] rsp_cell_value,
   output logic signed [aps_pkg::VALUE_WIDTH-1:0]      rsp_total_sum,
   output logic                                        rsp_last_result
);

   localparam int CW = $clog2(MAX_SIZE + 1);
   localparam int IW = $clog2(MAX_SIZE);
   localparam int VW = aps_pkg::VALUE_WIDTH;

   typedef enum logic [3:0] {
      S_IDLE, S_CLR, S_ROW, S_STEP, S_SCAN, S_SUB1, S_SUB2, S_UPD,
      S_ADJ, S_ADJ2, S_AUG, S_OSEL, S_ORD, S_OSUM
   } state_type;

   state_type state_ff;

   logic signed [VW-1:0] u_ff    [MAX_SIZE+1];
   logic signed [VW-1:0] v_ff    [MAX_SIZE+1];
   logic signed [VW-1:0] minv_ff [MAX_SIZE+1];
   logic [CW-1:0]        p_ff    [MAX_SIZE+1];
   logic [CW-1:0]        way_ff  [MAX_SIZE+1];
   logic [MAX_SIZE:0]    used_ff;

   logic [CW-1:0]        i_ff, j_ff, cur_ff, next_ff, r_ff;
   logic signed [VW-1:0] ur_ff, delta_ff, acc_ff, red_ff, run_ff;
   logic                 max_ff;

   logic                                        strobe_ff, last_ff;
   logic [aps_pkg::INDEX_OUT_WIDTH-1:0]         col_out_ff, row_out_ff;
   logic signed [aps_pkg::ENTRY_PORT_WIDTH-1:0] cell_out_ff;
   logic signed [VW-1:0]                        sum_out_ff;

   logic signed [VW-1:0] cell_wide, cost_eff, slack_min;
   logic signed [VW-1:0] alu_a, alu_b, alu_y;
   logic                 alu_sub;
   logic [CW-1:0]        owner_sel;

   // read address from current row and column, both one-based
   assign read_addr = {IW'(r_ff - CW'(1)), IW'(j_ff - CW'(1))};

   // stored entry widened and negated in maximize mode
   always_comb begin
      cell_wide = VW'($signed(read_data));
      cost_eff  = max_ff ? -cell_wide : cell_wide;
      slack_min = (red_ff < minv_ff[j_ff]) ? red_ff : minv_ff[j_ff];
      owner_sel = p_ff[j_ff];
   end

   // operand selection for the shared unit
   always_comb begin
      alu_a   = acc_ff;
      alu_b   = delta_ff;
      alu_sub = 1'b0;
      unique case (state_ff)
         S_SUB1: begin
            alu_a = ur_ff;
            alu_b = v_ff[j_ff];
         end
         S_SUB2: begin
            alu_a   = cost_eff;
            alu_b   = acc_ff;
            alu_sub = 1'b1;
         end
         S_ADJ: begin
            if (used_ff[j_ff]) begin
               alu_a = u_ff[owner_sel];
            end else begin
               alu_a   = minv_ff[j_ff];
               alu_sub = 1'b1;
            end
         end
         S_ADJ2: begin
            alu_a   = v_ff[j_ff];
            alu_sub = 1'b1;
         end
         S_OSUM: begin
            alu_a = run_ff;
            alu_b = cell_wide;
         end
         default: begin
            alu_a = acc_ff;
         end
      endcase
   end

   aps_alu u_alu (
      .op_a     (alu_a),
      .op_b     (alu_b),
      .subtract (alu_sub),
      .result   (alu_y)
   );

   // sequencer, tables and registered results
   always_ff @(posedge clock) begin
      strobe_ff <= !reset && (state_ff == S_OSUM);
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (start_ctl.go) begin
                  max_ff   <= start_ctl.maximize;
                  state_ff <= S_CLR;
               end
            end
            // zero potentials, owners and path
            S_CLR: begin
               for (int k = 0; k <= MAX_SIZE; k++) begin
                  u_ff[k]   <= '0;
                  v_ff[k]   <= '0;
                  p_ff[k]   <= '0;
                  way_ff[k] <= '0;
               end
               i_ff     <= CW'(1);
               state_ff <= S_ROW;
            end
            // start a new row
            S_ROW: begin
               p_ff[0] <= i_ff;
               for (int k = 0; k <= MAX_SIZE; k++) begin
                  minv_ff[k] <= aps_pkg::SLACK_TOP;
               end
               used_ff  <= '0;
               cur_ff   <= '0;
               state_ff <= S_STEP;
            end
            // mark current column, fetch its row potential
            S_STEP: begin
               r_ff              <= p_ff[cur_ff];
               ur_ff             <= u_ff[p_ff[cur_ff]];
               used_ff[cur_ff]   <= 1'b1;
               delta_ff          <= aps_pkg::SLACK_TOP;
               next_ff           <= '0;
               j_ff              <= CW'(1);
               state_ff          <= S_SCAN;
            end
            // visit columns, skip the marked ones
            S_SCAN: begin
               if (!used_ff[j_ff]) begin
                  state_ff <= S_SUB1;
               end else if (j_ff == size) begin
                  j_ff     <= '0;
                  state_ff <= S_ADJ;
               end else begin
                  j_ff <= j_ff + CW'(1);
               end
            end
            S_SUB1: begin
               acc_ff   <= alu_y;
               state_ff <= S_SUB2;
            end
            S_SUB2: begin
               red_ff   <= alu_y;
               state_ff <= S_UPD;
            end
            // slack update and running minimum
            S_UPD: begin
               if (red_ff < minv_ff[j_ff]) begin
                  minv_ff[j_ff] <= red_ff;
                  way_ff[j_ff]  <= cur_ff;
               end
               if (slack_min < delta_ff) begin
                  delta_ff <= slack_min;
                  next_ff  <= j_ff;
               end
               if (j_ff == size) begin
                  j_ff     <= '0;
                  state_ff <= S_ADJ;
               end else begin
                  j_ff     <= j_ff + CW'(1);
                  state_ff <= S_SCAN;
               end
            end
            // shift potentials and slacks by delta
            S_ADJ: begin
               if (used_ff[j_ff]) begin
                  u_ff[owner_sel] <= alu_y;
                  state_ff        <= S_ADJ2;
               end else begin
                  minv_ff[j_ff] <= alu_y;
                  if (j_ff == size) begin
                     cur_ff   <= next_ff;
                     state_ff <= (p_ff[next_ff] != '0 && next_ff != '0) ? S_STEP : S_AUG;
                  end else begin
                     j_ff <= j_ff + CW'(1);
                  end
               end
            end
            S_ADJ2: begin
               v_ff[j_ff] <= alu_y;
               if (j_ff == size) begin
                  cur_ff   <= next_ff;
                  state_ff <= (p_ff[next_ff] != '0 && next_ff != '0) ? S_STEP : S_AUG;
               end else begin
                  j_ff     <= j_ff + CW'(1);
                  state_ff <= S_ADJ;
               end
            end
            // walk the augmenting path back to the root
            S_AUG: begin
               if (cur_ff == '0) begin
                  if (i_ff == size) begin
                     j_ff     <= CW'(1);
                     run_ff   <= '0;
                     state_ff <= S_OSEL;
                  end else begin
                     i_ff     <= i_ff + CW'(1);
                     state_ff <= S_ROW;
                  end
               end else begin
                  p_ff[cur_ff] <= p_ff[way_ff[cur_ff]];
                  cur_ff       <= way_ff[cur_ff];
               end
            end
            // pick the owner row of the column
            S_OSEL: begin
               if (owner_sel == '0 || owner_sel > size) begin
                  r_ff <= CW'(1);
               end else begin
                  r_ff <= owner_sel;
               end
               state_ff <= S_ORD;
            end
            S_ORD: begin
               state_ff <= S_OSUM;
            end
            // emit one result
            S_OSUM: begin
               run_ff      <= alu_y;
               col_out_ff  <= aps_pkg::INDEX_OUT_WIDTH'(j_ff - CW'(1));
               row_out_ff  <= aps_pkg::INDEX_OUT_WIDTH'(r_ff - CW'(1));
               cell_out_ff <= cell_wide[aps_pkg::ENTRY_PORT_WIDTH-1:0];
               sum_out_ff  <= alu_y;
               last_ff     <= (j_ff == size);
               if (j_ff == size) begin
                  state_ff <= S_IDLE;
               end else begin
                  j_ff     <= j_ff + CW'(1);
                  state_ff <= S_OSEL;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign active           = (state_ff != S_IDLE) || strobe_ff;
   assign rsp_strobe       = strobe_ff;
   assign rsp_column_index = col_out_ff;
   assign rsp_assigned_row = row_out_ff;
   assign rsp_cell_value   = cell_out_ff;
   assign rsp_total_sum    = sum_out_ff;
   assign rsp_last_result  = last_ff;

endmodule

### src/assignment_problem_solver.sv
// assignment problem solver: matrix load control, cost store and solver
// depends on aps_pkg, aps_mem, aps_solver and the assertion macro header
//
// Usage:
//   Configure with csr_write_enable/csr_index/csr_write_data while idle:
//   register 0 is matrix_size (0 acts as 1, above MAX_SIZE acts as MAX_SIZE),
//   register 1 is maximize_mode. Writing matrix_size restarts the load.
//   Entries are given in row-major order, one per transfer: an entry is taken
//   when start is high and busy is low; back-to-back entries are taken.
//   After the last entry busy rises and the solver runs; the steps of the
//   sequencer share one 48-bit add/subtract unit. For each row, every
//   augmenting step scans the unvisited columns and then updates the
//   potentials and slacks of all columns. Results come one per column, with
//   rsp_strobe high for exactly one cycle; rsp_last_result marks the final
//   column, whose rsp_total_sum is the full total. The receiver cannot stall.
//   Synchronous reset returns to idle with matrix_size 16, maximize_mode 1
//   and an empty load; the cost store is not cleared.
`include "assignment_problem_solver_assert.svh"
module assignment_problem_solver #(
   parameter int MAX_SIZE = 16,
   parameter int ENTRY_WIDTH = 32
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        start,
   output logic                                        busy,
   input  logic signed [aps_pkg::ENTRY_PORT_WIDTH-1:0] req_entry_value,
   output logic                                        rsp_strobe,
   output logic [aps_pkg::INDEX_OUT_WIDTH-1:0]         rsp_column_index,
   output logic [aps_pkg::INDEX_OUT_WIDTH-1:0]         rsp_assigned_row,
   output logic signed [aps_pkg::ENTRY_PORT_WIDTH-1:0] rsp_cell_value,
   output logic signed [aps_pkg::VALUE_WIDTH-1:0]      rsp_total_sum,
   output logic                                        rsp_last_result,
   input  logic                                        csr_write_enable,
   input  logic [aps_pkg::CSR_INDEX_WIDTH-1:0]         csr_index,
   input  logic [aps_pkg::SIZE_REG_WIDTH-1:0]          csr_write_data
);

   localparam int CW = $clog2(MAX_SIZE + 1);
   localparam int IW = $clog2(MAX_SIZE);

   logic [aps_pkg::SIZE_REG_WIDTH-1:0] size_ff;
   logic                               max_ff;
   logic [IW-1:0]                      row_ff, col_ff;
   logic [CW-1:0]                      size_eff;
   logic                               accept, last_col, last_row, active;
   logic signed [aps_pkg::VALUE_WIDTH-1:0] entry_wide;
   logic [2*IW-1:0]                    read_addr;
   logic [ENTRY_WIDTH-1:0]             read_data;
   aps_pkg::aps_start_type             start_ctl;

   // size in use, clamped to 1..MAX_SIZE
   always_comb begin
      if (size_ff == '0) begin
         size_eff = CW'(1);
      end else if (int'(size_ff) > MAX_SIZE) begin
         size_eff = CW'(MAX_SIZE);
      end else begin
         size_eff = CW'(size_ff);
      end
   end

   assign accept     = start && !active;
   assign busy       = active;
   assign last_col   = (CW'(col_ff) == size_eff - CW'(1));
   assign last_row   = (CW'(row_ff) == size_eff - CW'(1));
   assign entry_wide = aps_pkg::VALUE_WIDTH'(req_entry_value);
   assign start_ctl  = '{go: accept && last_col && last_row, maximize: max_ff};

   // configuration registers and load position
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= aps_pkg::MATRIX_SIZE_RESET;
         max_ff  <= 1'b1;
         row_ff  <= '0;
         col_ff  <= '0;
      end else if (csr_write_enable) begin
         if (csr_index == aps_pkg::CSR_MATRIX_SIZE) begin
            size_ff <= csr_write_data;
            row_ff  <= '0;
            col_ff  <= '0;
         end else if (csr_index == aps_pkg::CSR_MAXIMIZE_MODE) begin
            max_ff <= csr_write_data[0];
         end
      end else if (accept) begin
         if (last_col) begin
            col_ff <= '0;
            row_ff <= last_row ? '0 : row_ff + IW'(1);
         end else begin
            col_ff <= col_ff + IW'(1);
         end
      end
   end

   aps_mem #(
      .ADDR_WIDTH (2 * IW),
      .DATA_WIDTH (ENTRY_WIDTH)
   ) u_mem (
      .clock        (clock),
      .write_enable (accept),
      .write_addr   ({row_ff, col_ff}),
      .write_data   (entry_wide[ENTRY_WIDTH-1:0]),
      .read_addr    (read_addr),
      .read_data    (read_data)
   );

   aps_solver #(
      .MAX_SIZE    (MAX_SIZE),
      .ENTRY_WIDTH (ENTRY_WIDTH)
   ) u_solver (
      .clock            (clock),
      .reset            (reset),
      .start_ctl        (start_ctl),
      .size             (size_eff),
      .read_addr        (read_addr),
      .read_data        (read_data),
      .active           (active),
      .rsp_strobe       (rsp_strobe),
      .rsp_column_index (rsp_column_index),
      .rsp_assigned_row (rsp_assigned_row),
      .rsp_cell_value   (rsp_cell_value),
      .rsp_total_sum    (rsp_total_sum),
      .rsp_last_result  (rsp_last_result)
   );

   // results are spaced apart, none follows an input transfer, each comes while busy
   `APS_ASSERT_NEXT(a_strobe_spaced, clock, reset, rsp_strobe, !rsp_strobe)
   `APS_ASSERT_NEXT(a_accept_no_result, clock, reset, start && !busy, !rsp_strobe)
   `APS_ASSERT_IMPLIES(a_result_while_busy, clock, reset, rsp_strobe, busy && !(start && !busy))

endmodule

### tb/tb_assignment_problem_solver.sv
// testbench for the assignment problem solver: loads cost matrices, predicts
// the optimal assignment in a local Hungarian solver and checks every result
// depends on aps_pkg and assignment_problem_solver
`timescale 1ns / 100ps

module tb_assignment_problem_solver;

   localparam int MAX_N = 16;
   localparam int IDX_W = aps_pkg::INDEX_OUT_WIDTH;
   localparam int ENT_W = aps_pkg::ENTRY_PORT_WIDTH;
   localparam int SUM_W = aps_pkg::VALUE_WIDTH;
   localparam int SIZE_W = aps_pkg::SIZE_REG_WIDTH;
   localparam int CSR_W = aps_pkg::CSR_INDEX_WIDTH;
   localparam longint SLACK_LIMIT = 64'sh7FFF_FFFF_FFFF;
   localparam longint CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic [IDX_W-1:0]        column;
      logic [IDX_W-1:0]        row;
      logic signed [ENT_W-1:0] entry;
      logic signed [SUM_W-1:0] total;
      logic                    last;
   } assignment_type;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic signed [ENT_W-1:0] req_entry_value;
   logic rsp_strobe;
   logic [IDX_W-1:0] rsp_column_index;
   logic [IDX_W-1:0] rsp_assigned_row;
   logic signed [ENT_W-1:0] rsp_cell_value;
   logic signed [SUM_W-1:0] rsp_total_sum;
   logic rsp_last_result;
   logic csr_write_enable;
   logic [CSR_W-1:0] csr_index;
   logic [SIZE_W-1:0] csr_write_data;

   // local copy of the block's configuration and matrix
   logic [SIZE_W-1:0] size_reg;
   logic maximize_reg;
   int fill_count;
   longint cost_mat [0:MAX_N-1][0:MAX_N-1];
   longint row_pot [0:MAX_N];
   longint col_pot [0:MAX_N];
   longint col_slack [0:MAX_N];
   int col_owner [0:MAX_N];
   int col_pred [0:MAX_N];
   bit col_seen [0:MAX_N];

   assignment_type expected_assignments[$];
   int errors;
   int sent_items;
   int matrices_solved;
   int checked_results;
   int gap_pct;
   longint cycle_count;

   assignment_problem_solver uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_entry_value(req_entry_value),
      .rsp_strobe(rsp_strobe), .rsp_column_index(rsp_column_index),
      .rsp_assigned_row(rsp_assigned_row), .rsp_cell_value(rsp_cell_value),
      .rsp_total_sum(rsp_total_sum), .rsp_last_result(rsp_last_result),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int used_size();
      if (size_reg == 0) return 1;
      if (size_reg > MAX_N) return MAX_N;
      return int'(size_reg);
   endfunction

   function automatic longint min_cost(int r, int c);
      return maximize_reg ? -cost_mat[r-1][c-1] : cost_mat[r-1][c-1];
   endfunction

   // hungarian method with potentials, then queue one result per column
   task automatic solve_assignment(int n);
      int i;
      int j;
      int cur;
      int nxt;
      int r;
      int prev;
      longint delta;
      longint red;
      longint running;
      assignment_type a;
      for (j = 0; j <= n; j++) begin
         row_pot[j] = 0;
         col_pot[j] = 0;
         col_owner[j] = 0;
         col_pred[j] = 0;
      end
      for (i = 1; i <= n; i++) begin
         cur = 0;
         col_owner[0] = i;
         for (j = 0; j <= n; j++) begin
            col_slack[j] = SLACK_LIMIT;
            col_seen[j] = 1'b0;
         end
         do begin
            r = col_owner[cur];
            nxt = 0;
            delta = SLACK_LIMIT;
            col_seen[cur] = 1'b1;
            for (j = 1; j <= n; j++) begin
               if (!col_seen[j]) begin
                  red = min_cost(r, j) - row_pot[r] - col_pot[j];
                  if (red < col_slack[j]) begin
                     col_slack[j] = red;
                     col_pred[j] = cur;
                  end
                  if (col_slack[j] < delta) begin
                     delta = col_slack[j];
                     nxt = j;
                  end
               end
            end
            for (j = 0; j <= n; j++) begin
               if (col_seen[j]) begin
                  row_pot[col_owner[j]] += delta;
                  col_pot[j] -= delta;
               end else begin
                  col_slack[j] -= delta;
               end
            end
            cur = nxt;
         end while (col_owner[cur] != 0 && cur != 0);
         // augment along the predecessor chain
         while (cur != 0) begin
            prev = col_pred[cur];
            col_owner[cur] = col_owner[prev];
            cur = prev;
         end
      end
      running = 0;
      for (j = 1; j <= n; j++) begin
         r = col_owner[j];
         if (r < 1 || r > n) r = 1;
         running += cost_mat[r-1][j-1];
         a.column = IDX_W'(j - 1);
         a.row = IDX_W'(r - 1);
         a.entry = cost_mat[r-1][j-1][ENT_W-1:0];
         a.total = running[SUM_W-1:0];
         a.last = (j == n);
         expected_assignments.push_back(a);
      end
      matrices_solved++;
   endtask

   // record one accepted entry in the local matrix
   task automatic load_entry(logic signed [ENT_W-1:0] value);
      int n;
      n = used_size();
      if (fill_count >= n * n) fill_count = 0;
      cost_mat[fill_count / n][fill_count % n] = longint'(value);
      fill_count++;
      if (fill_count >= n * n) begin
         fill_count = 0;
         solve_assignment(n);
      end
   endtask

   // one entry transfer; start stays high on return
   task automatic send_entry(logic signed [ENT_W-1:0] value);
      bit taken;
      if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1'b1;
      req_entry_value <= value;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end
      sent_items++;
      load_entry(value);
   endtask

   // wait until no result is outstanding and the solver is idle
   task automatic drain();
      start <= 1'b0;
      while (expected_assignments.size() != 0 || busy) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_W-1:0] idx, logic [SIZE_W-1:0] data);
      start <= 1'b0;
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == aps_pkg::CSR_MATRIX_SIZE) begin
         size_reg = data;
         fill_count = 0;
      end else begin
         maximize_reg = data[0];
      end
      @(posedge clock);
   endtask

   function automatic logic signed [ENT_W-1:0] random_entry(int spread);
      int pick;
      pick = $urandom_range(9);
      if (pick < 1) return ($urandom_range(1)) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      if (pick < 5) return $signed($urandom_range(2 * spread)) - spread;
      return $signed($urandom());
   endfunction

   task automatic send_matrix(int n, int spread);
      repeat (n * n) send_entry(random_entry(spread));
   endtask

   // defaults after reset: 16x16, maximize
   task automatic test_reset_defaults();
      send_matrix(MAX_N, 50);
      drain();
   endtask

   // single-cell matrices at the field extremes, size 0 acting as 1
   task automatic test_single_cell();
      write_csr(aps_pkg::CSR_MATRIX_SIZE, 5'd1);
      write_csr(aps_pkg::CSR_MAXIMIZE_MODE, 5'd0);
      send_entry(32'sh7FFF_FFFF);
      send_entry(32'sh8000_0000);
      drain();
      write_csr(aps_pkg::CSR_MATRIX_SIZE, 5'd0);
      write_csr(aps_pkg::CSR_MAXIMIZE_MODE, 5'd1);
      send_entry(32'sh8000_0000);
      send_entry(-32'sd1);
      drain();
   endtask

   // equal entries exercise lowest-column tie breaking, then extremes
   task automatic test_ties_and_extremes();
      write_csr(aps_pkg::CSR_MATRIX_SIZE, 5'd2);
      write_csr(aps_pkg::CSR_MAXIMIZE_MODE, 5'd0);
      repeat (4) send_entry(32'sd7);
      send_entry(32'sh7FFF_FFFF);
      send_entry(32'sh8000_0000);
      send_entry(32'sh8000_0000);
      send_entry(32'sh7FFF_FFFF);
      drain();
   endtask

   // size write restarts a partial load; mode change mid-load applies to all
   task automatic test_mid_load_changes();
      write_csr(aps_pkg::CSR_MATRIX_SIZE, 5'd3);
      repeat (4) send_entry(random_entry(100));
      write_csr(aps_pkg::CSR_MATRIX_SIZE, 5'd2);
      send_entry(32'sd3);
      send_entry(32'sd1);
      write_csr(aps_pkg::CSR_MAXIMIZE_MODE, 5'd1);
      send_entry(32'sd2);
      send_entry(32'sd9);
      drain();
   endtask

   // random small matrices over sizes, modes and idle phases
   task automatic test_random_matrices(int phase_count);
      int phase;
      for (phase = 0; phase < phase_count; phase++) begin
         unique case (phase % 3)
            0: gap_pct = 0;
            1: gap_pct = 54;
            default: gap_pct = 31;
         endcase
         write_csr(aps_pkg::CSR_MATRIX_SIZE, SIZE_W'($urandom_range(3)));
         write_csr(aps_pkg::CSR_MAXIMIZE_MODE, SIZE_W'($urandom_range(1)));
         send_matrix(used_size(), $urandom_range(1, 1000));
         drain();
      end
      gap_pct = 0;
   endtask

   // result checker against the oldest expectation
   always @(posedge clock) begin
      assignment_type want;
      if (!reset && rsp_strobe) begin
         if (expected_assignments.size() == 0) begin
            $display("%0t: unexpected result col=%0d row=%0d", $time,
                     rsp_column_index, rsp_assigned_row);
            errors++;
         end else begin
            want = expected_assignments.pop_front();
            checked_results++;
            if (rsp_column_index !== want.column || rsp_assigned_row !== want.row ||
                rsp_cell_value !== want.entry || rsp_total_sum !== want.total ||
                rsp_last_result !== want.last) begin
               $display("%0t: mismatch expected col=%0d row=%0d cell=%0d sum=%0d last=%0b",
                        $time, want.column, want.row, want.entry, want.total, want.last);
               $display("%0t:           actual col=%0d row=%0d cell=%0d sum=%0d last=%0b",
                        $time, rsp_column_index, rsp_assigned_row, rsp_cell_value,
                        rsp_total_sum, rsp_last_result);
               errors++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time,
                  expected_assignments.size());
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      errors = 0;
      sent_items = 0;
      matrices_solved = 0;
      checked_results = 0;
      gap_pct = 0;
      cycle_count = 0;
      size_reg = aps_pkg::MATRIX_SIZE_RESET;
      maximize_reg = 1'b1;
      fill_count = 0;
      reset = 1'b1;
      start = 1'b0;
      req_entry_value = '0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_single_cell();
      test_ties_and_extremes();
      test_mid_load_changes();
      test_random_matrices(6);

      drain();
      repeat (50) @(posedge clock);
      if (expected_assignments.size() != 0) errors++;
      $display("covered %0d entries, %0d matrices, %0d results checked", sent_items,
               matrices_solved, checked_results);
      $display("default 16x16 load, sizes 0 to 3, both modes, mid-load changes, idle gaps");
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### files.f
+incdir+src
src/aps_pkg.sv
src/aps_mem.sv
src/aps_alu.sv
src/aps_solver.sv
src/assignment_problem_solver.sv
tb/tb_assignment_problem_solver.sv
